// File: hw/rtl/cfae_pkg.sv
// shared types, constants and helpers for the can frame to ascii encoder
package cfae_pkg;

    localparam int FRAME_FIFO_DEPTH_DEF = 128;

    localparam int NUM_BYTES  = 8;
    localparam int IDENT_W    = 29;
    localparam int DLC_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int CHAR_IDX_W = 5;
    localparam int IN_DATA_W  = 104;
    localparam int STD_ID_W   = 11;

    localparam logic [DLC_W-1:0]  MAX_DLC  = 4'd8;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_STD = 8'h74;   // 't'
    localparam logic [CHAR_W-1:0] CHAR_EXT = 8'h54;   // 'T'

    localparam logic [CHAR_W-1:0] HEX_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [NUM_BYTES-1:0][7:0] data;
        logic [DLC_W-1:0]          length;
        logic                      extended;
        logic [IDENT_W-1:0]        ident;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_EMIT
    } t_bk_state;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        return HEX_TABLE[nib];
    endfunction

endpackage

// File: hw/rtl/cfae_ram.sv
// generic single-write, single-read ram with registered read data
module cfae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/cfae_fifo.sv
// frame queue between front and back, ram storage with fill count
module cfae_fifo import cfae_pkg::*; #(
    parameter int DEPTH = FRAME_FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  t_frame     i_wr_frame,
    input  logic       i_rd_en,
    output t_frame     o_rd_frame,
    output t_fifo_stat o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [$bits(t_frame)-1:0] rd_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_ADDR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_ADDR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr_en && i_rd_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    cfae_ram #(
        .WIDTH ($bits(t_frame)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (i_wr_frame),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_bits)
    );

    assign o_rd_frame   = t_frame'(rd_bits);
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);

endmodule

// File: hw/rtl/cfae_front.sv
// input side: collect enable register, frame filtering and queue write
module cfae_front import cfae_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  t_fifo_stat           i_fifo_stat,
    output logic                 o_wr_en,
    output t_frame               o_wr_frame,
    output logic                 o_enable
);

    logic r_enable;
    logic keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_enable <= i_cfg_wr_data;
        end
    end

    // dropped frames are still taken, they just never reach the queue
    assign s_axis_tready = !i_fifo_stat.full;

    always_comb begin
        o_wr_frame.data     = s_axis_tdata[96:33];
        o_wr_frame.length   = s_axis_tdata[32:29];
        o_wr_frame.extended = s_axis_tuser;
        // standard frames carry only the low 11 identifier bits
        o_wr_frame.ident    = s_axis_tuser ? s_axis_tdata[IDENT_W-1:0]
                            : {{(IDENT_W-STD_ID_W){1'b0}}, s_axis_tdata[STD_ID_W-1:0]};
    end

    assign keep     = r_enable && (s_axis_tdata[32:29] <= MAX_DLC);
    assign o_wr_en  = s_axis_tvalid && s_axis_tready && keep;
    assign o_enable = r_enable;

endmodule

// File: hw/rtl/cfae_back.sv
// output side: sends a queued frame's ascii line a char a cycle unless stalled
module cfae_back import cfae_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fifo_stat        i_fifo_stat,
    output logic              o_rd_en,
    input  t_frame            i_rd_frame,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CHAR_W-1:0] m_axis_tdata,
    output logic              m_axis_tlast
);

    t_bk_state r_state;
    t_bk_state n_state;

    t_frame                r_frame;
    logic [CHAR_IDX_W-1:0] r_idx;
    logic                  r_m_valid;
    logic [CHAR_W-1:0]     r_m_data;
    logic                  r_m_last;

    logic                  load;
    logic                  emit;
    logic [CHAR_IDX_W-1:0] hdr_len;
    logic [CHAR_IDX_W-1:0] id_sel;
    logic [CHAR_IDX_W-1:0] data_pos;
    logic [31:0]           id_pad;
    logic [7:0]            cur_byte;
    logic [CHAR_W-1:0]     cur_char;
    logic                  cur_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    n_state = BK_LOAD;
                end
            end
            BK_LOAD: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (emit && cur_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_rd_en = 1'b0;
        load    = 1'b0;
        emit    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_rd_en = !i_fifo_stat.empty;
            end
            BK_LOAD: begin
                load = 1'b1;
            end
            BK_EMIT: begin
                emit = !r_m_valid || m_axis_tready;
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    // character for the current line position
    always_comb begin
        hdr_len  = r_frame.extended ? CHAR_IDX_W'(9) : CHAR_IDX_W'(4);
        id_sel   = r_frame.extended ? (CHAR_IDX_W'(8) - r_idx) : (CHAR_IDX_W'(3) - r_idx);
        data_pos = r_idx - hdr_len - 1'b1;
        id_pad   = {{(32-IDENT_W){1'b0}}, r_frame.ident};
        cur_byte = r_frame.data[data_pos[3:1]];
        cur_last = 1'b0;
        if (r_idx == '0) begin
            cur_char = r_frame.extended ? CHAR_EXT : CHAR_STD;
        end else if (r_idx < hdr_len) begin
            cur_char = hex_char(id_pad[id_sel[2:0]*4 +: 4]);
        end else if (r_idx == hdr_len) begin
            cur_char = hex_char(r_frame.length);
        end else if (data_pos < {r_frame.length, 1'b0}) begin
            cur_char = hex_char(data_pos[0] ? cur_byte[3:0] : cur_byte[7:4]);
        end else begin
            cur_char = CHAR_CR;
            cur_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame <= i_rd_frame;
            r_idx   <= '0;
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
        end
        if (emit) begin
            r_m_data <= cur_char;
            r_m_last <= cur_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

// File: hw/rtl/can_frame_to_ascii_encoder_top.sv
// top level of the can frame to ascii line encoder
//
// turns received can frames into slcan text lines, one ascii char per request
// input request: s_axis_tdata holds ident, length and byte0..byte7, s_axis_tuser
//   flags an extended identifier; taken when s_axis_tvalid and s_axis_tready
// output request: m_axis_tdata is one char, m_axis_tlast marks the closing cr
// config: i_cfg_wr_en writes i_cfg_wr_data into collect_enable (reset 0)
// frames are dropped with no output while collection is off or dlc is above 8;
//   dropped frames are still taken at the input
// kept frames wait in a ram queue of FRAME_FIFO_DEPTH entries; s_axis_tready
//   drops only while the queue is full
// input to output: first char of a frame passes the queue write, ram read,
//   frame load and char output register when the line side is idle
// throughput: a line of 6 + 2*dlc (standard) or 11 + 2*dlc (extended) chars
//   goes out one char per cycle unless the receiver stalls, and the idle and
//   load states fetch the next frame between lines
// a stalled receiver holds the current char; the queue keeps taking frames
// reset empties the queue and clears collect_enable; no clearing pass
module can_frame_to_ascii_encoder_top import cfae_pkg::*; #(
    parameter int FRAME_FIFO_DEPTH = FRAME_FIFO_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,  // collect_enable
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [28:0] ident, [32:29] length, [40:33] byte0 .. [96:89] byte7, rest zero
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,   // [0] extended
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [CHAR_W-1:0]    m_axis_tdata,   // [7:0] char_out
    output logic                 m_axis_tlast
);

    t_fifo_stat fifo_stat;
    t_frame     wr_frame;
    t_frame     rd_frame;
    logic       wr_en;
    logic       rd_en;
    logic       enable;

    // front: filter and queue
    cfae_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_fifo_stat   (fifo_stat),
        .o_wr_en       (wr_en),
        .o_wr_frame    (wr_frame),
        .o_enable      (enable)
    );

    // frame queue
    cfae_fifo #(
        .DEPTH (FRAME_FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_frame (wr_frame),
        .i_rd_en    (rd_en),
        .o_rd_frame (rd_frame),
        .o_stat     (fifo_stat)
    );

    // back: line serializer
    cfae_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_stat   (fifo_stat),
        .o_rd_en       (rd_en),
        .i_rd_frame    (rd_frame),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // queue never reports full and empty together
    a_fifo_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue full and empty at once");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !fifo_stat.empty)
        else $error("pop from empty queue");

    // last char of a line is always the carriage return
    a_last_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == CHAR_CR))
        else $error("tlast on a char other than cr");

    // nothing enters the queue while collection is off
    a_drop_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !enable |-> !wr_en)
        else $error("frame queued while collection disabled");
`endif

endmodule
